// File: hdl/sliding_window_median_top_macros.svh
// assertion macros for the running median block
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define SWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/swm_pkg.sv
`default_nettype none
package swm_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int WS_W        = 7;
	localparam int SUM_W       = SAMPLE_BITS + 1;
	localparam int MEDIAN_W    = 33;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;
	localparam int GROUPS      = 8;
	localparam int GROUP_SIZE  = MAX_WINDOW / GROUPS;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;

	typedef struct packed {
		logic    evict;
		logic    insert;
		sample_t old_val;
		sample_t new_val;
	} cell_ctl_t;

	// window size clipped to 1..MAX_WINDOW
	function automatic logic [CNT_W-1:0] eff_size(input logic [WS_W-1:0] ws);
		logic [CNT_W-1:0] k;
		if (ws == '0) begin
			k = CNT_W'(1);
		end else if (int'(ws) > MAX_WINDOW) begin
			k = CNT_W'(MAX_WINDOW);
		end else begin
			k = CNT_W'(ws);
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// File: hdl/swm_cell.sv
`default_nettype none
module swm_cell
	import swm_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire logic      occ_e,
	input  wire sample_t   right_val,
	input  wire sample_t   left_tmp,
	input  wire logic      left_place,
	output sample_t        val,
	output sample_t        tmp,
	output logic           place
);

	sample_t val_q;
	sample_t nxt;
	logic    ge;

	always_comb begin
		// removal point is the first occupied cell not below the oldest value
		ge    = occ && (val_q >= ctl.old_val);
		tmp   = (ctl.evict && ge) ? right_val : val_q;
		// insertion point is the first cell above the new value, or the first free one
		place = !occ_e || (tmp > ctl.new_val);
		if (!ctl.insert) begin
			nxt = tmp;
		end else if (left_place) begin
			nxt = left_tmp;
		end else if (place) begin
			nxt = ctl.new_val;
		end else begin
			nxt = tmp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.evict || ctl.insert) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule
`default_nettype wire

// File: hdl/swm_ring.sv
`default_nettype none
module swm_ring
	import swm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire sample_t          wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output sample_t               rdata
);

	sample_t ring_q [MAX_WINDOW];
	sample_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ring_q[waddr] <= wdata;
		end
	end

	// write-through so the oldest sample is ready even when just written
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= ring_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hdl/swm_fifo.sv
`default_nettype none
module swm_fifo
	import swm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire median_t               push_data,
	input  wire logic                  pop_ready,
	output logic                       valid,
	output median_t                    data,
	output logic [FIFO_CNT_W-1:0]      count
);

	median_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_q];
	assign count = cnt_q;
	assign pop   = valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// File: hdl/sliding_window_median_top.sv
// Running median filter over the last window_size signed samples (1 to 64, values out of
// range are clipped). The window is held sorted in a row of 64 compare-and-shift cells;
// each accepted sample drops the oldest one if the window is full and is inserted in the
// same cycle, so one sample is taken per clock while the output queue has room and no
// surplus is dropped. A result, the sum of the two middle elements (median times two),
// for each sample that leaves the window full passes the cell and group registers into a
// four-entry output queue. Lowering window_size first drops the surplus (s_tready low).
// tuser set on a sample empties the window first. Write window_size only while idle.
`default_nettype none
module sliding_window_median_top
	import swm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // sample
	input  wire logic                 s_tuser,   // restart
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // median_twice, zero pad
	input  wire logic                 cfg_we,
	input  wire logic [WS_W-1:0]      cfg_wdata
);

	logic [WS_W-1:0]       ws_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      head_q;
	logic                  pend_q;
	logic                  valid_s1;

	logic [CNT_W-1:0]      k;
	logic                  trim;
	logic                  room;
	logic                  accept;
	logic                  clear;
	logic                  evict;
	logic                  result;
	logic [CNT_W-1:0]      fill_b;
	logic [CNT_W-1:0]      fill_e;
	logic [CNT_W-1:0]      fill_n;
	logic [IDX_W-1:0]      head_b;
	logic [IDX_W-1:0]      head_e;
	logic [IDX_W-1:0]      waddr;
	logic [FIFO_CNT_W:0]   inflight;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	sample_t               in_val;
	sample_t               old_val;
	cell_ctl_t             ctl;

	logic [MAX_WINDOW-1:0] occ;
	logic [MAX_WINDOW-1:0] occ_e;
	logic [MAX_WINDOW-1:0] cell_place;
	logic [MAX_WINDOW-1:0] lo_sel;
	logic [MAX_WINDOW-1:0] hi_sel;
	sample_t               cell_val [MAX_WINDOW];
	sample_t               cell_tmp [MAX_WINDOW];
	logic [IDX_W-1:0]      lo_idx;
	logic [IDX_W-1:0]      hi_idx;

	sample_t               lo_part [GROUPS];
	sample_t               hi_part [GROUPS];
	sample_t               lo_part_s1 [GROUPS];
	sample_t               hi_part_s1 [GROUPS];
	sample_t               lo_all;
	sample_t               hi_all;
	logic signed [SUM_W-1:0] sum;
	median_t               median;
	median_t               fifo_data;

	// control
	always_comb begin
		k        = eff_size(ws_q);
		trim     = fill_q > k;
		inflight = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(pend_q)
			+ (FIFO_CNT_W + 1)'(valid_s1);
		room     = inflight < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
		s_tready = !trim && room;
		accept   = s_tvalid && s_tready;
		clear    = accept && s_tuser;
		in_val   = sample_t'(s_tdata[SAMPLE_BITS-1:0]);
		fill_b   = clear ? '0 : fill_q;
		head_b   = clear ? '0 : head_q;
		evict    = trim || (accept && !s_tuser && (fill_q >= k));
		fill_e   = fill_b - CNT_W'(evict);
		head_e   = head_b + IDX_W'(evict);
		fill_n   = fill_e + CNT_W'(accept);
		waddr    = head_e + fill_e[IDX_W-1:0];
		result   = accept && (fill_n == k);
		ctl      = '{evict: evict, insert: accept, old_val: old_val, new_val: in_val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= WS_RESET;
			fill_q   <= '0;
			head_q   <= '0;
			pend_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			fill_q   <= fill_n;
			head_q   <= head_e;
			pend_q   <= result;
			valid_s1 <= pend_q;
		end
	end

	// arrival order
	swm_ring u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (in_val),
		.raddr (head_e),
		.rdata (old_val)
	);

	// sorted cell row
	assign lo_idx = IDX_W'((k - CNT_W'(1)) >> 1);
	assign hi_idx = IDX_W'(k >> 1);

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		sample_t right_v;
		sample_t left_t;
		logic    left_p;

		assign occ[i]    = CNT_W'(i) < fill_b;
		assign occ_e[i]  = CNT_W'(i) < fill_e;
		assign lo_sel[i] = (lo_idx == IDX_W'(i));
		assign hi_sel[i] = (hi_idx == IDX_W'(i));

		if (i == MAX_WINDOW - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid
			assign right_v = cell_val[i + 1];
		end

		if (i == 0) begin : g_first
			assign left_t = '0;
			assign left_p = 1'b0;
		end else begin : g_rest
			assign left_t = cell_tmp[i - 1];
			assign left_p = cell_place[i - 1];
		end

		swm_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ[i]),
			.occ_e      (occ_e[i]),
			.right_val  (right_v),
			.left_tmp   (left_t),
			.left_place (left_p),
			.val        (cell_val[i]),
			.tmp        (cell_tmp[i]),
			.place      (cell_place[i])
		);
	end

	// middle pick, group level
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			lo_part[g] = '0;
			hi_part[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				lo_part[g] = lo_part[g]
					| (lo_sel[g * GROUP_SIZE + j] ? cell_val[g * GROUP_SIZE + j] : '0);
				hi_part[g] = hi_part[g]
					| (hi_sel[g * GROUP_SIZE + j] ? cell_val[g * GROUP_SIZE + j] : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			lo_part_s1[g] <= lo_part[g];
			hi_part_s1[g] <= hi_part[g];
		end
	end

	// middle pick, final level and sum
	always_comb begin
		lo_all = '0;
		hi_all = '0;
		for (int g = 0; g < GROUPS; g++) begin
			lo_all = lo_all | lo_part_s1[g];
			hi_all = hi_all | hi_part_s1[g];
		end
		sum    = SUM_W'(lo_all) + SUM_W'(hi_all);
		median = MEDIAN_W'(sum);
	end

	swm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (median),
		.pop_ready (m_tready),
		.valid     (m_tvalid),
		.data      (fifo_data),
		.count     (fifo_cnt)
	);

	assign m_tdata = {{(M_TDATA_W - MEDIAN_W){1'b0}}, fifo_data};

endmodule
`default_nettype wire

// File: hdl/swm_checker.sv
`default_nettype none
`include "sliding_window_median_top_macros.svh"
module swm_checker
	import swm_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	`SWM_ASSERT_SAME(a_rise_needs_item, $rose(m_tvalid), $past(s_tvalid && s_tready, 3), "result without an item three cycles before")
	`SWM_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:MEDIAN_W] == '0, "nonzero pad bits on result")
	`SWM_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`SWM_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);
`default_nettype wire

// File: tb/sliding_window_median_top_tb.sv
`timescale 1ns / 1ps
module sliding_window_median_top_tb;
	import swm_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CALM_TAIL    = 200;
	localparam int HOLD_CYCLES  = 400;

	typedef enum logic {ROW_SAMPLE, ROW_WS} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		sample_t   val;
		logic      rst;
		logic      known;
		median_t   want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [24] = '{
		'{ROW_SAMPLE, 32'sd5, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, -32'sd7, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd100, 1'b0, 1'b1, 33'sd10},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
		'{ROW_SAMPLE, 32'sd0, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd0, 1'b0, 1'b1, 33'sd0},
		'{ROW_WS, 32'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, -32'sd1, 1'b0, 1'b1, 33'h1_FFFF_FFFE},
		'{ROW_SAMPLE, 32'sd7, 1'b0, 1'b1, 33'sd14},
		'{ROW_WS, 32'sd4, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd1, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd2, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, -32'sd4, 1'b0, 1'b0, '0},
		'{ROW_WS, 32'sd2, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd9, 1'b0, 1'b0, '0},
		'{ROW_WS, 32'sd127, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'sd42, 1'b1, 1'b0, '0}
	};

	localparam logic [WS_W-1:0] EDGE_SIZES [6] = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd65, 7'd127};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // sample
	logic                 s_tuser = 1'b0; // restart
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // median_twice, zero pad
	logic                 cfg_we = 1'b0;
	logic [WS_W-1:0]      cfg_wdata = '0;

	// window model
	sample_t         win_sorted [MAX_WINDOW];
	sample_t         win_ring [MAX_WINDOW];
	int              ring_oldest = 0;
	int              win_count = 0;
	logic [WS_W-1:0] ws_reg = WS_RESET;

	median_t medians_q [$];

	int  err_cnt = 0;
	int  cycle_cnt = 0;
	int  samples_sent = 0;
	int  medians_checked = 0;
	int  ws_writes = 0;
	int  restarts_sent = 0;
	bit  idle_on = 1'b1;
	bit  hold_request = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  stall_left = 0;

	sliding_window_median_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int window_len(input logic [WS_W-1:0] ws);
		int k;
		k = int'(ws);
		if (k < 1) begin
			k = 1;
		end
		if (k > MAX_WINDOW) begin
			k = MAX_WINDOW;
		end
		return k;
	endfunction

	function automatic bit median_step(input sample_t v, input logic rst, output median_t med);
		int      k;
		int      pos;
		int      i;
		sample_t oldest;
		k = window_len(ws_reg);
		med = '0;
		if (rst) begin
			win_count = 0;
			ring_oldest = 0;
		end
		// drop oldest samples, first sorted copy of each value
		while (win_count >= k) begin
			oldest = win_ring[ring_oldest];
			pos = 0;
			while (pos < win_count && win_sorted[pos] < oldest) pos++;
			if (pos >= win_count) begin
				pos = win_count - 1;
			end
			for (i = pos; i + 1 < win_count; i++) win_sorted[i] = win_sorted[i + 1];
			win_count--;
			ring_oldest = (ring_oldest + 1) % MAX_WINDOW;
		end
		// insert after all equal values
		pos = 0;
		while (pos < win_count && win_sorted[pos] <= v) pos++;
		for (i = win_count; i > pos; i--) win_sorted[i] = win_sorted[i - 1];
		win_sorted[pos] = v;
		win_ring[(ring_oldest + win_count) % MAX_WINDOW] = v;
		win_count++;
		if (win_count != k) begin
			return 1'b0;
		end
		med = median_t'(win_sorted[k / 2]) + median_t'(win_sorted[(k - 1) / 2]);
		return 1'b1;
	endfunction

	function automatic sample_t rand_sample();
		sample_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: begin
				v = sample_t'($urandom_range(0, 6)) - 32'sd3;
			end
			default: begin
				v = $urandom();
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic send_sample(input sample_t v, input logic rst, input logic known,
			input median_t want);
		median_t med;
		bit      has_med;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= rst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		has_med = median_step(v, rst, med);
		if (known) begin
			medians_q = {medians_q, want};
		end else if (has_med) begin
			medians_q = {medians_q, med};
		end
		samples_sent++;
		if (rst) begin
			restarts_sent++;
		end
	endtask

	task automatic set_window(input logic [WS_W-1:0] ws);
		s_tvalid <= 1'b0;
		while (medians_q.size() != 0) @(posedge clk);
		// let samples that made no median leave the pipeline
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ws;
		@(posedge clk);
		cfg_we <= 1'b0;
		ws_reg = ws;
		ws_writes++;
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("sliding_window_median_top verification failed");
			$finish;
		end
	end

	// output side: check and drive m_tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (medians_q.size() == 0) begin
				report_mismatch($sformatf("unexpected median %h", m_tdata));
			end else begin
				if (m_tdata[MEDIAN_W-1:0] !== medians_q[0]) begin
					report_mismatch($sformatf("median_twice got %0d want %0d",
						$signed(m_tdata[MEDIAN_W-1:0]), medians_q[0]));
				end
				if (m_tdata[M_TDATA_W-1:MEDIAN_W] !== '0) begin
					report_mismatch($sformatf("pad bits not zero: %h", m_tdata));
				end
				void'(medians_q.pop_front());
				medians_checked++;
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
		end else if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(1, 18) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int              rand_sent;
		int              phase;
		int              len;
		int              j;
		logic            rst;
		logic [WS_W-1:0] ws;
		rand_sent = 0;
		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reset window size first
		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_WS) begin
				set_window(DIRECTED[r].val[WS_W-1:0]);
			end else begin
				send_sample(DIRECTED[r].val, DIRECTED[r].rst, DIRECTED[r].known,
					DIRECTED[r].want);
			end
		end

		// random phases, each with its own window size
		while (rand_sent < RANDOM_ITEMS) begin
			if (phase < 6) begin
				ws = EDGE_SIZES[phase];
			end else if ($urandom_range(0, 3) == 0) begin
				ws = WS_W'($urandom_range(0, 127));
			end else begin
				ws = WS_W'($urandom_range(1, 12));
			end
			set_window(ws);
			if (window_len(ws) > 16) begin
				len = $urandom_range(120, 220);
			end else begin
				len = $urandom_range(30, 120);
			end
			idle_on = (phase % 4 != 3);
			for (j = 0; j < len && rand_sent < RANDOM_ITEMS; j++) begin
				if (rand_sent >= RANDOM_ITEMS - CALM_TAIL) begin
					idle_on = 1'b0;
				end
				if (rand_sent == 400) begin
					hold_request = 1'b1;
				end
				rst = ($urandom_range(0, 39) == 0) || (j == 0 && $urandom_range(0, 1) == 1);
				send_sample(rand_sample(), rst, 1'b0, '0);
				rand_sent++;
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		while (medians_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d samples (%0d restarts), checked %0d medians", samples_sent,
			restarts_sent, medians_checked);
		$display("window size written %0d times, incl. 0, 1, 2, 64 and out-of-range values",
			ws_writes);
		if (err_cnt == 0) begin
			$display("sliding_window_median_top verification clean");
		end else begin
			$display("sliding_window_median_top verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_ring.sv
hdl/swm_fifo.sv
hdl/sliding_window_median_top.sv
hdl/swm_checker.sv
tb/sliding_window_median_top_tb.sv
